// File: rtl/core/qdd_pkg.sv
// Shared types, constants and the transition table of the quadrature detent decoder.
`timescale 1ns / 1ps
`default_nettype none
package qdd_pkg;

	localparam int POSITION_WIDTH_DEF = 32;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int CPD_W      = 5;
	localparam int REM_W      = 4;
	localparam int RATE_W     = 8;
	localparam int MS_W       = 32;
	localparam int WIN_W      = 16;
	localparam int STEP_W     = 9;
	localparam int CPOS_W     = 32;
	localparam int IN_TDATA_W  = 40;
	localparam int OUT_TDATA_W = 48;

	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_ENABLE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CPD          = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ACCEL_ENABLE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ACCEL_RATE   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ACCEL_WINDOW = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_IDLE_TIMEOUT = 3'd5;

	localparam logic [1:0] LINES_LOW  = 2'b00;
	localparam logic [1:0] LINES_HIGH = 2'b11;

	localparam logic [1:0] DIR_NONE = 2'd0;
	localparam logic [1:0] DIR_UP   = 2'd1;
	localparam logic [1:0] DIR_DOWN = 2'd2;

	typedef struct packed {
		logic              enable;
		logic [CPD_W-1:0]  cpd;
		logic              accel_en;
		logic [RATE_W-1:0] rate;
		logic [WIN_W-1:0]  window;
		logic [WIN_W-1:0]  timeout;
	} cfg_t;

	// old/new line pair -> count direction
	function automatic logic [1:0] move_dir(input logic [3:0] idx);
		logic [1:0] d;
		unique case (idx)
			4'd1, 4'd7, 4'd8, 4'd14:  d = DIR_UP;
			4'd2, 4'd4, 4'd11, 4'd13: d = DIR_DOWN;
			default:                  d = DIR_NONE;
		endcase
		return d;
	endfunction

endpackage
`default_nettype wire

// File: rtl/core/quadrature_detent_decoder_unit.sv
// Quadrature detent decoder top level: sequencer, position state and stream ports.
//
// Each accepted sample of lines A/B plus a millisecond timestamp moves a signed
// count position through the quadrature transition table. A move that puts the
// position a full detent past the last report emits one result with the signed
// detent step (optionally accelerated) and the count position. A sample that
// moves one count and reports, and an idle sample that checks the detent snap,
// each pass through the shared bit-serial divider, which produces one quotient
// bit per cycle over the full position width; a move that does not report and
// an idle sample that skips the snap check do not use it. Input and
// configuration are taken only while the sequencer is idle; a finished result
// waits in the output register without stalling the next sample, and a later
// report waits in its last state until that register is free.
`timescale 1ns / 1ps
`default_nettype none
module quadrature_detent_decoder_unit
	import qdd_pkg::*;
#(
	parameter int POSITION_WIDTH = POSITION_WIDTH_DEF
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    cfg_valid,
	output logic                   cfg_ready,
	input  wire [CFG_IDX_W-1:0]    cfg_index,
	input  wire [CFG_DATA_W-1:0]   cfg_data,
	input  wire                    s_axis_tvalid,
	output logic                   s_axis_tready,
	input  wire [IN_TDATA_W-1:0]   s_axis_tdata,  // line_a, line_b, now_ms[31:0], zero pad
	output logic                   m_axis_tvalid,
	input  wire                    m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata   // detent_step[8:0], count_position[31:0], pad
);

	localparam int PW = POSITION_WIDTH;

	localparam logic [2:0] ST_IDLE    = 3'd0;
	localparam logic [2:0] ST_IDLECHK = 3'd1;
	localparam logic [2:0] ST_DIFF    = 3'd2;
	localparam logic [2:0] ST_ABS     = 3'd3;
	localparam logic [2:0] ST_PREP    = 3'd4;
	localparam logic [2:0] ST_LOAD    = 3'd5;
	localparam logic [2:0] ST_DIV     = 3'd6;
	localparam logic [2:0] ST_FIN     = 3'd7;

	cfg_t cfg;

	logic [2:0]        state_q;
	logic [1:0]        prev_q;
	logic [PW-1:0]     pos_q;
	logic [PW-1:0]     rep_q;
	logic [MS_W-1:0]   last_change_q;
	logic [MS_W-1:0]   last_report_q;
	logic [MS_W-1:0]   now_q;
	logic [PW-1:0]     work_q;
	logic              neg_q;
	logic              snap_q;
	logic              fast_q;

	logic              out_valid_q;
	logic [STEP_W-1:0] step_q;
	logic [CPOS_W-1:0] cpos_q;

	logic              in_req;
	logic [1:0]        cur;
	logic [1:0]        dir;
	logic [MS_W-1:0]   now_in;
	logic              div_start;
	logic              div_busy;
	logic [PW-1:0]     div_quo;
	logic [REM_W-1:0]  div_rem;
	logic [REM_W-1:0]  half;
	logic [CPOS_W-1:0] cpos_next;
	logic [RATE_W-1:0] stepmag;
	logic              snap_ok;
	logic              out_free;
	logic              out_load;

	assign cfg_ready     = state_q == ST_IDLE;
	assign s_axis_tready = state_q == ST_IDLE;
	assign in_req        = s_axis_tvalid && s_axis_tready;
	assign cur           = {s_axis_tdata[0], s_axis_tdata[1]};
	assign now_in        = s_axis_tdata[33:2];
	assign dir           = move_dir({prev_q, cur});
	assign half          = cfg.cpd[CPD_W-1:1];
	assign div_start     = state_q == ST_LOAD;
	assign out_free      = !out_valid_q || m_axis_tready;
	assign out_load      = state_q == ST_FIN && !snap_q && out_free;

	qdd_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	qdd_div #(
		.PW (PW)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (work_q),
		.den    (cfg.cpd),
		.busy   (div_busy),
		.quo    (div_quo),
		.rem    (div_rem)
	);

	generate
		if (PW >= CPOS_W) begin : g_wide
			assign cpos_next = pos_q[CPOS_W-1:0];
		end else begin : g_narrow
			assign cpos_next = {{(CPOS_W-PW){pos_q[PW-1]}}, pos_q};
		end
	endgenerate

	always_comb begin
		priority if (cfg.accel_en && fast_q && div_quo == PW'(1)) begin
			stepmag = cfg.rate;
		end else if (|div_quo[PW-1:RATE_W]) begin
			stepmag = '1;
		end else begin
			stepmag = div_quo[RATE_W-1:0];
		end
	end

	// snapped value is within one count of the position
	assign snap_ok = ({1'b0, div_rem} <= {1'b0, half} + (REM_W+1)'(1)) &&
		({1'b0, div_rem} + (REM_W+1)'(1) >= {1'b0, half});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			prev_q        <= LINES_HIGH;
			pos_q         <= '0;
			rep_q         <= '0;
			last_change_q <= '0;
			last_report_q <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tvalid && m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_req && cfg.enable) begin
						if (cur != prev_q) begin
							prev_q <= cur;
							if (dir != DIR_NONE) begin
								pos_q         <= (dir == DIR_UP) ? pos_q + PW'(1) : pos_q - PW'(1);
								last_change_q <= now_in;
								state_q       <= ST_DIFF;
							end
						end else begin
							state_q <= ST_IDLECHK;
						end
					end
				end
				ST_IDLECHK: begin
					if ((now_q - last_change_q > MS_W'(cfg.timeout)) &&
						(prev_q == LINES_LOW || prev_q == LINES_HIGH)) begin
						state_q <= ST_ABS;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_DIFF: state_q <= ST_ABS;
				ST_ABS:  state_q <= ST_PREP;
				ST_PREP: begin
					if (snap_q || work_q >= PW'(cfg.cpd)) begin
						state_q <= ST_LOAD;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_LOAD: state_q <= ST_DIV;
				ST_DIV: begin
					if (!div_busy) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (snap_q) begin
						if (snap_ok) begin
							pos_q <= neg_q ? PW'(div_rem) - work_q : work_q - PW'(div_rem);
							rep_q <= neg_q ? PW'(div_rem) - work_q : work_q - PW'(div_rem);
						end
						state_q <= ST_IDLE;
					end else if (out_free) begin
						rep_q         <= neg_q ? pos_q + PW'(div_rem) : pos_q - PW'(div_rem);
						last_report_q <= now_q;
						state_q       <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				now_q  <= now_in;
				snap_q <= 1'b0;
			end
			ST_IDLECHK: begin
				work_q <= pos_q;
				snap_q <= 1'b1;
			end
			ST_DIFF: begin
				work_q <= pos_q - rep_q;
				fast_q <= (now_q - last_report_q) < MS_W'(cfg.window);
			end
			ST_ABS: begin
				neg_q  <= work_q[PW-1];
				work_q <= work_q[PW-1] ? -work_q : work_q;
			end
			ST_PREP: begin
				if (snap_q) begin
					work_q <= work_q + PW'(half);
				end
			end
			ST_FIN: begin
				if (!snap_q && out_free) begin
					step_q <= neg_q ? -{1'b0, stepmag} : {1'b0, stepmag};
					cpos_q <= cpos_next;
				end
			end
			default: ;
		endcase
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(OUT_TDATA_W-STEP_W-CPOS_W){1'b0}}, cpos_q, step_q};

`ifndef SYNTHESIS
	a_out_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_FIN))
		else $error("result loaded outside finish state");
	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !div_busy)
		else $error("divider busy while sequencer idle");
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN) |-> ({1'b0, div_rem} < cfg.cpd))
		else $error("divider remainder not below detent size");
	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> (state_q == ST_IDLE || state_q == ST_IDLECHK
		|| state_q == ST_DIFF))
		else $error("unexpected state after sample request");
`endif

endmodule
`default_nettype wire

// File: rtl/core/qdd_cfg.sv
// Configuration register file with detent size clamping.
`timescale 1ns / 1ps
`default_nettype none
module qdd_cfg
	import qdd_pkg::*;
(
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   wr_en,
	input  wire [CFG_IDX_W-1:0]   wr_index,
	input  wire [CFG_DATA_W-1:0]  wr_data,
	output cfg_t                  cfg
);

	logic              enable_q;
	logic [CPD_W-1:0]  cpd_q;
	logic              accel_en_q;
	logic [RATE_W-1:0] rate_q;
	logic [WIN_W-1:0]  window_q;
	logic [WIN_W-1:0]  timeout_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q   <= 1'b1;
			cpd_q      <= CPD_W'(4);
			accel_en_q <= 1'b0;
			rate_q     <= RATE_W'(3);
			window_q   <= WIN_W'(50);
			timeout_q  <= WIN_W'(1000);
		end else if (wr_en) begin
			unique case (wr_index)
				REG_BLOCK_ENABLE: enable_q   <= wr_data[0];
				REG_CPD:          cpd_q      <= wr_data[CPD_W-1:0];
				REG_ACCEL_ENABLE: accel_en_q <= wr_data[0];
				REG_ACCEL_RATE:   rate_q     <= wr_data[RATE_W-1:0];
				REG_ACCEL_WINDOW: window_q   <= wr_data;
				REG_IDLE_TIMEOUT: timeout_q  <= wr_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		cfg.enable   = enable_q;
		cfg.accel_en = accel_en_q;
		cfg.rate     = rate_q;
		cfg.window   = window_q;
		cfg.timeout  = timeout_q;
		priority if (cpd_q == '0) begin
			cfg.cpd = CPD_W'(1);
		end else if (cpd_q > CPD_W'(16)) begin
			cfg.cpd = CPD_W'(16);
		end else begin
			cfg.cpd = cpd_q;
		end
	end

endmodule
`default_nettype wire

// File: rtl/core/qdd_div.sv
// Bit-serial restoring divider by a small detent count, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module qdd_div
	import qdd_pkg::*;
#(
	parameter int PW = POSITION_WIDTH_DEF
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               start,
	input  wire [PW-1:0]      num,
	input  wire [CPD_W-1:0]   den,
	output logic              busy,
	output logic [PW-1:0]     quo,
	output logic [REM_W-1:0]  rem
);

	localparam int CW = $clog2(PW + 1);

	logic [CW-1:0]    cnt_q;
	logic [PW-1:0]    sh_q;
	logic [REM_W-1:0] rem_q;
	logic [CPD_W-1:0] trial;
	logic [CPD_W-1:0] diff;
	logic             ge;

	assign trial = {rem_q, sh_q[PW-1]};
	assign ge    = trial >= den;
	assign diff  = trial - den;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CW'(PW);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sh_q  <= num;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			sh_q  <= {sh_q[PW-2:0], ge};
			rem_q <= ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
		end
	end

	assign busy = cnt_q != '0;
	assign quo  = sh_q;
	assign rem  = rem_q;

endmodule
`default_nettype wire
